// ===== src/chip8_instruction_execute_core_defines.svh =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core_defines
// Assertion macros for the CHIP-8 execute core.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define C8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define C8_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define C8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/c8ex_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ex_pkg
// Shared constants, codes and font table of the CHIP-8 execute core.
// ----------------------------------------------------------------------------
`default_nettype none
package c8ex_pkg;
    localparam int DISP_W     = 64;
    localparam int DISP_H     = 32;
    localparam int FONT_BASE  = 80;
    localparam int FONT_BYTES = 5;
    localparam int STACK_TOP  = 3744;
    localparam int MEM_BYTES  = 4096;
    localparam int NPIX       = DISP_W * DISP_H;
    localparam int AW         = $clog2(MEM_BYTES);
    localparam int PW         = $clog2(NPIX);
    localparam int CW         = $clog2(DISP_W);
    localparam int RW         = $clog2(DISP_H);
    localparam int FONT_END   = FONT_BASE + 16 * FONT_BYTES;

    localparam logic [2:0] CMD_EXEC = 3'd0;
    localparam logic [2:0] CMD_WMEM = 3'd1;
    localparam logic [2:0] CMD_RMEM = 3'd2;
    localparam logic [2:0] CMD_RPIX = 3'd3;
    localparam logic [2:0] CMD_RREG = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] opcode;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [7:0]  random_byte;
        logic [15:0] keys_down;
        logic        key_event_valid;
        logic [3:0]  key_event_code;
        logic [7:0]  delay_now;
    } t_in;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        logic [7:0]  read_data;
        logic        key_wait;
        logic        delay_write;
        logic        sound_write;
        logic [7:0]  timer_value;
        logic        display_changed;
    } t_out;

    function automatic logic [7:0] font_byte(input logic [6:0] k);
        logic [7:0] g [80];
        g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        return (k < 7'd80) ? g[k] : 8'h00;
    endfunction
endpackage
`default_nettype wire

// ===== src/c8ex_if.sv =====
// ----------------------------------------------------------------------------
// c8ex_in_if / c8ex_out_if
// Valid/ready channels of the CHIP-8 execute core.
// ----------------------------------------------------------------------------
`default_nettype none
interface c8ex_in_if;
    logic           valid;
    logic           ready;
    c8ex_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface c8ex_out_if;
    logic           valid;
    logic           ready;
    c8ex_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/chip8_instruction_execute_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core: CHIP-8 execute unit, one result per transfer
// Register, jump and skip ops go from decode straight to the result; reads, call, return,
//   BCD, FX55, FX65, DXYN and 00E0 (pixel sweep) pass through further states first.
// One item in flight: the next input is accepted in the cycle after the result transfer.
// Reset (sync, low): a sweep over all addresses loads font, clears memory and pixel RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chip8_instruction_execute_core_defines.svh"
module chip8_instruction_execute_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    c8ex_in_if.sink        i_in,
    c8ex_out_if.source     o_out
);
    localparam int AW = c8ex_pkg::AW;
    localparam int PW = c8ex_pkg::PW;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DEC   = 10'b0000000100,  // main memory read issued, wait data
        S_MRD   = 10'b0000001000,  // memory data valid
        S_DRAW  = 10'b0000010000,  // read pixel for current column
        S_DPIX  = 10'b0000100000,  // pixel data valid, write toggle
        S_CLR   = 10'b0001000000,
        S_BLK   = 10'b0010000000,  // block store/load, BCD, call push
        S_PRD   = 10'b0100000000,  // pixel read command
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    c8ex_pkg::t_in  r_in;
    c8ex_pkg::t_out r_res;

    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [11:0] r_pc;
    logic [11:0] r_sp;
    logic [AW:0] r_ctr;       // init and clear sweeps / block step
    logic [3:0]  r_row;
    logic [3:0]  r_col;
    logic [7:0]  r_bits;
    logic        r_hit;
    logic [11:0] r_tmp;
    logic [11:0] n_pc;

    // memory ports
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [7:0]    m_wd, m_rd;
    logic          p_we;
    logic [PW-1:0] p_addr;
    logic          p_wd, p_rd;

    c8ex_ram #(.DW(8), .DEPTH(c8ex_pkg::MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m_rd));
    c8ex_ram #(.DW(1), .DEPTH(c8ex_pkg::NPIX)) u_pix (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wd), .o_rdata(p_rd));

    wire [15:0] op = r_in.opcode;
    wire [3:0]  ox = op[11:8];
    wire [3:0]  oy = op[7:4];
    wire [3:0]  on = op[3:0];
    wire [7:0]  nn = op[7:0];
    wire [7:0]  vx = r_v[ox];
    wire [7:0]  vy = r_v[oy];
    wire [11:0] pc2 = r_pc + 12'd2;

    wire [c8ex_pkg::CW-1:0] c0 = vx[c8ex_pkg::CW-1:0];
    wire [c8ex_pkg::RW-1:0] r0 = vy[c8ex_pkg::RW-1:0];
    wire [8:0] col_abs = 9'(c0) + 9'(r_col);
    wire [8:0] row_abs = 9'(r0) + 9'(r_row);
    wire [PW-1:0] pix_idx = PW'(row_abs) * PW'(c8ex_pkg::DISP_W) + PW'(col_abs);
    wire row_ok = (row_abs < 9'(c8ex_pkg::DISP_H)) && (5'(r_row) < 5'(on));

    // BCD digits through small compare chains
    logic [3:0] d_h, d_t, d_o;
    always_comb begin
        logic [7:0] t;
        d_h = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
        t = vx - ((vx >= 8'd200) ? 8'd200 : (vx >= 8'd100) ? 8'd100 : 8'd0);
        d_t = 4'd0;
        for (int k = 9; k >= 1; k--) begin
            if (d_t == 4'd0 && t >= 8'(k * 10)) d_t = 4'(k);
        end
        d_o = 4'(t - 8'(d_t) * 8'd10);
    end

    wire is_draw = (op[15:12] == 4'hD);
    wire is_f    = (op[15:12] == 4'hF);
    wire is_ret  = (op == 16'h00EE);
    wire is_call = (op[15:12] == 4'h2);
    wire is_bcd  = is_f && nn == 8'h33;
    wire is_st   = is_f && nn == 8'h55;
    wire is_ld   = is_f && nn == 8'h65;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);

    // pc/index fields follow the live registers while the result waits
    always_comb begin
        o_out.payload = r_res;
        o_out.payload.next_pc = r_pc;
        o_out.payload.index_value = r_i;
    end

    // pc after jumps, skips and key wait; call/return finish it later
    always_comb begin
        n_pc = pc2;
        unique case (op[15:12])
            4'h1: n_pc = op[11:0];
            4'h3: if (vx == nn) n_pc = pc2 + 12'd2;
            4'h4: if (vx != nn) n_pc = pc2 + 12'd2;
            4'h5: if (on == 4'h0 && vx == vy) n_pc = pc2 + 12'd2;
            4'h9: if (on == 4'h0 && vx != vy) n_pc = pc2 + 12'd2;
            4'hB: n_pc = op[11:0] + {4'h0, r_v[0]};
            4'hE: begin
                if (nn == 8'h9E && r_in.keys_down[vx[3:0]])
                    n_pc = pc2 + 12'd2;
                else if (nn == 8'hA1 && !r_in.keys_down[vx[3:0]])
                    n_pc = pc2 + 12'd2;
            end
            4'hF: if (nn == 8'h0A && !r_in.key_event_valid) n_pc = r_pc;
            default: begin
            end
        endcase
    end

    // memory port select
    always_comb begin
        m_we = 1'b0; m_addr = '0; m_wd = '0;
        p_we = 1'b0; p_addr = '0; p_wd = 1'b0;
        unique case (r_state)
            S_INIT: begin
                if (!r_ctr[AW]) begin
                    m_we = 1'b1; m_addr = r_ctr[AW-1:0];
                    m_wd = (r_ctr[AW-1:0] >= AW'(c8ex_pkg::FONT_BASE) &&
                            r_ctr[AW-1:0] < AW'(c8ex_pkg::FONT_END)) ?
                           c8ex_pkg::font_byte(7'(r_ctr[AW-1:0] -
                                              AW'(c8ex_pkg::FONT_BASE))) : 8'h00;
                end
                p_we = 1'b1; p_addr = r_ctr[PW-1:0];
            end
            S_IDLE, S_OUT, S_MRD: begin
            end
            S_DEC: begin
                if (r_in.command == c8ex_pkg::CMD_WMEM) begin
                    m_we = 1'b1; m_addr = r_in.address; m_wd = r_in.write_data;
                end else if (r_in.command == c8ex_pkg::CMD_RMEM) begin
                    m_addr = r_in.address;
                end else if (is_ret) begin
                    m_addr = r_sp;
                end else if (is_draw) begin
                    m_addr = AW'(r_i + 16'(r_row));
                end
                if (r_in.command == c8ex_pkg::CMD_RPIX) p_addr = r_in.address[PW-1:0];
            end
            S_DRAW: p_addr = pix_idx;
            S_DPIX: begin
                p_addr = pix_idx;
                p_we = r_bits[7 - r_col[2:0]];
                p_wd = ~p_rd;
            end
            S_CLR: begin
                p_we = 1'b1; p_addr = r_ctr[PW-1:0];
            end
            S_PRD: p_addr = r_in.address[PW-1:0];
            S_BLK: begin
                if (is_call) begin
                    // r_pc already holds the advanced pc
                    m_we = 1'b1;
                    m_addr = r_sp + 12'(r_ctr[0]);
                    m_wd = r_ctr[0] ? r_pc[7:0] : {4'h0, r_pc[11:8]};
                end else if (is_bcd) begin
                    m_we = 1'b1; m_addr = AW'(r_i + 16'(r_ctr[1:0]));
                    m_wd = (r_ctr[1:0] == 2'd0) ? {4'h0, d_h} :
                           (r_ctr[1:0] == 2'd1) ? {4'h0, d_t} : {4'h0, d_o};
                end else if (is_st) begin
                    m_we = 1'b1; m_addr = AW'(r_i + 16'(r_ctr[3:0]));
                    m_wd = r_v[r_ctr[3:0]];
                end else begin
                    m_addr = AW'(r_i + 16'(r_ctr[3:0]));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ctr   <= '0;
            r_pc    <= 12'h200;
            r_sp    <= 12'(c8ex_pkg::STACK_TOP);
            r_i     <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_ctr <= r_ctr + 1'b1;
                    if (r_ctr == (AW+1)'(c8ex_pkg::MEM_BYTES)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in <= i_in.payload;
                        r_state <= S_DEC;
                        r_ctr <= '0;
                        r_row <= '0;
                        r_col <= '0;
                        r_hit <= 1'b0;
                        r_res <= '0;
                    end
                end
                S_DEC: begin
                    unique case (r_in.command)
                        c8ex_pkg::CMD_EXEC: begin
                            // draw rows and the second stack read come back here;
                            // pc advances only on the first pass
                            if (r_row == 4'd0 && !r_ctr[0]) r_pc <= n_pc;
                            if (is_ret || is_draw) r_state <= S_MRD;
                            else if (op == 16'h00E0) r_state <= S_CLR;
                            else if (is_call) begin
                                r_sp <= r_sp - 12'd2;
                                r_state <= S_BLK;
                            end else if (is_bcd || is_st || is_ld) r_state <= S_BLK;
                            else begin
                                r_state <= S_OUT;
                                unique case (op[15:12])
                                    4'h6: r_v[ox] <= nn;
                                    4'h7: r_v[ox] <= vx + nn;
                                    4'h8: begin
                                        unique case (on)
                                            4'h0: r_v[ox] <= vy;
                                            4'h1: r_v[ox] <= vx | vy;
                                            4'h2: r_v[ox] <= vx & vy;
                                            4'h3: r_v[ox] <= vx ^ vy;
                                            4'h4: begin
                                                r_v[ox] <= vx + vy;
                                                r_v[15] <= {7'd0,
                                                    ({1'b0, vx} + {1'b0, vy}) > 9'hFF};
                                            end
                                            4'h5: begin
                                                r_v[ox] <= vx - vy;
                                                r_v[15] <= {7'd0, vx >= vy};
                                            end
                                            4'h6: begin
                                                r_v[ox] <= {1'b0, vy[7:1]};
                                                r_v[15] <= {7'd0, vy[0]};
                                            end
                                            4'h7: begin
                                                r_v[ox] <= vy - vx;
                                                r_v[15] <= {7'd0, vy >= vx};
                                            end
                                            4'hE: begin
                                                r_v[ox] <= {vy[6:0], 1'b0};
                                                r_v[15] <= {7'd0, vy[7]};
                                            end
                                            default: begin
                                            end
                                        endcase
                                    end
                                    4'hA: r_i <= {4'h0, op[11:0]};
                                    4'hC: r_v[ox] <= r_in.random_byte & nn;
                                    4'hF: begin
                                        unique case (nn)
                                            8'h07: r_v[ox] <= r_in.delay_now;
                                            8'h0A: begin
                                                if (r_in.key_event_valid)
                                                    r_v[ox] <= {4'h0, r_in.key_event_code};
                                                else
                                                    r_res.key_wait <= 1'b1;
                                            end
                                            8'h15: begin
                                                r_res.delay_write <= 1'b1;
                                                r_res.timer_value <= vx;
                                            end
                                            8'h18: begin
                                                r_res.sound_write <= 1'b1;
                                                r_res.timer_value <= vx;
                                            end
                                            8'h1E: r_i <= r_i + {8'h0, vx};
                                            8'h29: r_i <= 16'(c8ex_pkg::FONT_BASE) +
                                                          16'(vx[3:0]) *
                                                          16'(c8ex_pkg::FONT_BYTES);
                                            default: begin
                                            end
                                        endcase
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        c8ex_pkg::CMD_RMEM: r_state <= S_MRD;
                        c8ex_pkg::CMD_RPIX: r_state <= S_PRD;
                        c8ex_pkg::CMD_RREG: begin
                            r_res.read_data <= (r_in.address < 12'd16) ?
                                               r_v[r_in.address[3:0]] : 8'h00;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_MRD: begin
                    if (r_in.command == c8ex_pkg::CMD_RMEM) begin
                        r_res.read_data <= m_rd;
                        r_state <= S_OUT;
                    end else if (is_ret) begin
                        // two reads: high byte then low byte
                        if (!r_ctr[0]) begin
                            r_tmp <= {m_rd[3:0], 8'h00};
                            r_ctr <= (AW+1)'(1);
                            r_sp <= r_sp + 12'd1;
                            r_state <= S_DEC;
                            r_in.command <= c8ex_pkg::CMD_EXEC;
                        end
                        if (r_ctr[0]) begin
                            r_pc <= {r_tmp[11:8], m_rd};
                            r_sp <= r_sp + 12'd1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_bits <= m_rd;
                        r_col <= '0;
                        r_state <= row_ok ? S_DRAW : S_OUT;
                        if (!row_ok) r_v[15] <= {7'd0, r_hit};
                    end
                end
                S_DRAW: begin
                    if (col_abs >= 9'(c8ex_pkg::DISP_W)) begin
                        r_row <= r_row + 4'd1;
                        r_state <= S_DEC;
                    end else r_state <= S_DPIX;
                end
                S_DPIX: begin
                    if (r_bits[7 - r_col[2:0]]) begin
                        r_res.display_changed <= 1'b1;
                        if (p_rd) r_hit <= 1'b1;
                    end
                    if (r_col == 4'd7) begin
                        r_row <= r_row + 4'd1;
                        r_state <= S_DEC;
                    end else begin
                        r_col <= r_col + 4'd1;
                        r_state <= S_DRAW;
                    end
                end
                S_CLR: begin
                    // previous cycle's address read back: any lit pixel
                    if (r_ctr != '0 && p_rd) r_res.display_changed <= 1'b1;
                    r_ctr <= r_ctr + 1'b1;
                    if (r_ctr == (AW+1)'(c8ex_pkg::NPIX)) r_state <= S_OUT;
                end
                S_PRD: begin
                    r_res.read_data <= (r_in.address < 12'(c8ex_pkg::NPIX)) ?
                                       {7'd0, p_rd} : 8'h00;
                    r_state <= S_OUT;
                end
                S_BLK: begin
                    r_ctr <= r_ctr + 1'b1;
                    if (is_ld && r_ctr != '0) r_v[r_ctr[3:0] - 4'd1] <= m_rd;
                    if (is_call && r_ctr[0]) begin
                        r_pc <= op[11:0];
                        r_state <= S_OUT;
                    end
                    if (is_bcd && r_ctr[1:0] == 2'd2) r_state <= S_OUT;
                    if (is_st && r_ctr[3:0] == ox) begin
                        r_i <= r_i + 16'(ox) + 16'd1;
                        r_state <= S_OUT;
                    end
                    if (is_ld && r_ctr[4:0] == 5'(ox) + 5'd1) begin
                        r_i <= r_i + 16'(ox) + 16'd1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    `C8_ASSERT_IMPL(a_one_side, i_clk, i_rst_n, o_out.valid, !i_in.ready,
        "input accepted while result pending")
    `C8_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready,
        o_out.valid, "result dropped before transfer")
    `C8_ASSERT_IMPL(a_no_wr_idle, i_clk, i_rst_n, i_in.ready, !m_we && !p_we,
        "memory written while idle")
endmodule
`default_nettype wire

// ===== src/c8ex_ram.sv =====
// ----------------------------------------------------------------------------
// c8ex_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module c8ex_ram #(
    parameter int DW = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DW-1:0]            i_wdata,
    output logic [DW-1:0]                 o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire
